FILE: rtl/source_byte_tokenizer_assert.svh
// assertion macros shared by the tokenizer modules
// no dependencies
`ifndef SOURCE_BYTE_TOKENIZER_ASSERT_SVH
`define SOURCE_BYTE_TOKENIZER_ASSERT_SVH
// implication checked every cycle outside reset
`define SBT_ASSERT_IMP(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication outside reset
`define SBT_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

FILE: rtl/sbt_pkg.sv
// shared types and constants of the source byte tokenizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sbt_pkg;
  localparam int KEYWORD_COUNT = 12;
  localparam int KEYWORD_MAX_BYTES = 24;
  localparam int OFFSET_WIDTH = 24;
  localparam int LINE_WIDTH = 16;

  localparam logic [5:0] K_EOF = 6'd0;
  localparam logic [5:0] K_IDENT = 6'd13;
  localparam logic [5:0] K_NUMBER = 6'd14;
  localparam logic [5:0] K_STRING = 6'd15;
  localparam logic [5:0] K_PLUS = 6'd16;
  localparam logic [5:0] K_MINUS = 6'd17;
  localparam logic [5:0] K_STAR = 6'd18;
  localparam logic [5:0] K_DIV = 6'd19;
  localparam logic [5:0] K_MOD = 6'd20;
  localparam logic [5:0] K_ASSIGN = 6'd21;
  localparam logic [5:0] K_EQ = 6'd22;
  localparam logic [5:0] K_NE = 6'd23;
  localparam logic [5:0] K_GT = 6'd24;
  localparam logic [5:0] K_LT = 6'd25;
  localparam logic [5:0] K_GE = 6'd26;
  localparam logic [5:0] K_LE = 6'd27;
  localparam logic [5:0] K_AND = 6'd28;
  localparam logic [5:0] K_OR = 6'd29;
  localparam logic [5:0] K_NOT = 6'd30;
  localparam logic [5:0] K_SEMI = 6'd31;
  localparam logic [5:0] K_COMMA = 6'd32;
  localparam logic [5:0] K_LPAREN = 6'd33;
  localparam logic [5:0] K_RPAREN = 6'd34;
  localparam logic [5:0] K_LBRACE = 6'd35;
  localparam logic [5:0] K_RBRACE = 6'd36;
  localparam logic [5:0] K_ERROR = 6'd37;

  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_UNEXPECTED = 2'd1;
  localparam logic [1:0] E_UNTERMINATED = 2'd2;

  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

  // class flags of a source byte, worked out in the front end
  typedef struct packed {
    logic ws;
    logic part;
    logic start;
    logic digit;
  } byte_class_t;

  // token as it leaves the scanner
  typedef struct packed {
    logic [5:0]              kind;
    logic [1:0]              err;
    logic [OFFSET_WIDTH-1:0] offset;
    logic [7:0]              length;
    logic [LINE_WIDTH-1:0]   line;
    logic [LINE_WIDTH-1:0]   column;
    logic [30:0]             value;
    logic                    frac;
    logic                    ovf;
    logic                    last;
  } token_t;

  // keyword lengths in bytes
  function automatic logic [7:0] kw_len(input logic [3:0] k);
    case (k)
      4'd0: kw_len = 8'd24;
      4'd1: kw_len = 8'd15;
      4'd2: kw_len = 8'd12;
      4'd3: kw_len = 8'd15;
      4'd4: kw_len = 8'd9;
      4'd5: kw_len = 8'd12;
      4'd6: kw_len = 8'd9;
      4'd7: kw_len = 8'd12;
      4'd8: kw_len = 8'd9;
      default: kw_len = 8'd12;
    endcase
  endfunction

  // every keyword is a run of three-byte characters E0 xx yy; the rom
  // holds the second and third byte of each character
  function automatic logic [15:0] kw_char(input logic [3:0] k, input logic [2:0] i);
    logic [127:0] row;
    row = '0;
    case (k)
      4'd0: row = {16'hA4AA, 16'hA582, 16'hA4B0, 16'hA58D,
                   16'hA4A3, 16'hA4BE, 16'hA482, 16'hA495};
      4'd1: row = {16'hA4A6, 16'hA4B6, 16'hA4AE, 16'hA4B2, 16'hA4B5, 48'h0};
      4'd2: row = {16'hA4B5, 16'hA4B0, 16'hA58D, 16'hA4A3, 64'h0};
      4'd3: row = {16'hA4B6, 16'hA582, 16'hA4A8, 16'hA58D, 16'hA4AF, 48'h0};
      4'd4: row = {16'hA485, 16'hA497, 16'hA4B0, 80'h0};
      4'd5: row = {16'hA4B5, 16'hA4B0, 16'hA4A8, 16'hA4BE, 64'h0};
      4'd6: row = {16'hA4A6, 16'hA58C, 16'hA4B0, 80'h0};
      4'd7: row = {16'hA49C, 16'hA4AC, 16'hA4A4, 16'hA495, 64'h0};
      4'd8: row = {16'hA495, 16'hA4B0, 16'hA58B, 80'h0};
      4'd9: row = {16'hA4B0, 16'hA581, 16'hA495, 16'hA58B, 64'h0};
      4'd10: row = {16'hA49C, 16'hA4BE, 16'hA4B0, 16'hA580, 64'h0};
      default: row = {16'hA4B5, 16'hA4BE, 16'hA4AA, 16'hA4B8, 64'h0};
    endcase
    kw_char = row[127 - 16*i -: 16];
  endfunction

  // keyword byte at a position; the rom row is laid out as 24 bytes, past it reads zero
  function automatic logic [7:0] kw_byte(input logic [3:0] k, input logic [7:0] pos);
    logic [191:0] bytes;
    logic [15:0]  ch;
    bytes = '0;
    for (int i = 0; i < 8; i++) begin
      ch = kw_char(k, 3'(i));
      bytes[191 - 24*i -: 24] = {8'hE0, ch};
    end
    if (pos < 8'd24) kw_byte = bytes[191 - 8*pos[4:0] -: 8];
    else kw_byte = 8'h00;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/sbt_front.sv
// front end: takes a source byte, classifies it and stores it with its
// class flags in a two-entry queue; depends on sbt_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "source_byte_tokenizer_assert.svh"
module sbt_front (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end,
  output logic            q_valid,
  input  wire logic       q_pop,
  output logic [7:0]      q_byte,
  output sbt_pkg::byte_class_t q_cls,
  output logic            q_end
);
  import sbt_pkg::*;

  logic [12:0] slot [2];
  logic        rd_ptr;
  logic        wr_ptr;
  logic [1:0]  fill;
  logic        push;
  byte_class_t in_cls;

  // byte classes
  assign in_cls.digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
  assign in_cls.start = (in_byte >= 8'h61 && in_byte <= 8'h7A)
                      || (in_byte >= 8'h41 && in_byte <= 8'h5A)
                      || in_byte == 8'h5F || in_byte >= 8'hE0;
  assign in_cls.part = in_cls.start || in_cls.digit || in_byte >= 8'h80;
  assign in_cls.ws = in_byte == 8'h20 || in_byte == 8'h0D || in_byte == 8'h09
                   || in_byte == 8'h0A;

  assign in_stall = (fill == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (fill != 2'd0);
  assign {q_end, q_cls, q_byte} = slot[rd_ptr];

  // queue pointers and storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= {in_end, in_cls, in_byte};
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

  `SBT_ASSERT_IMP(a_pop_nonempty, q_pop, q_valid, "pop from empty byte queue")
  `SBT_ASSERT_NEXT(a_full_holds, in_stall && !q_pop, in_stall, "queue lost an entry")
  `SBT_ASSERT_IMP(a_fill_range, 1'b1, fill != 2'd3, "queue fill out of range")
endmodule
`default_nettype wire

FILE: rtl/sbt_back.sv
// back end: scanner state machine, up to four tokens per byte, one token
// beat per cycle into an output register while it is not stalled; depends on sbt_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "source_byte_tokenizer_assert.svh"
module sbt_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  output logic            q_pop,
  input  wire logic [7:0] q_byte,
  input  wire sbt_pkg::byte_class_t q_cls,
  input  wire logic       q_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output sbt_pkg::token_t out_tok
);
  import sbt_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_NUM_DOT, M_FRACTION, M_STRING, M_COMMENT, M_OP
  } mode_t;

  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;
  localparam logic [LINE_WIDTH-1:0] LINE_MAX = '1;

  mode_t                   scan_mode;
  logic [2:0]              pending_operator;
  logic [OFFSET_WIDTH-1:0] byte_offset, start_offset;
  logic [7:0]              length_count;
  logic [LINE_WIDTH-1:0]   line_count, column_count, start_line, start_column;
  logic [30:0]             number_accumulator;
  logic                    overflow_seen;
  logic [KEYWORD_COUNT-1:0] keyword_alive;

  // queued token list for the current byte
  token_t     tl [4];
  logic [2:0] tl_count;
  logic [2:0] tl_idx;
  logic       busy;

  mode_t                   m_n;
  logic [2:0]              p_n;
  logic [OFFSET_WIDTH-1:0] bo_n, so_n;
  logic [7:0]              lc_n;
  logic [LINE_WIDTH-1:0]   ln_n, cn_n, sl_n, sc_n;
  logic [30:0]             acc_n;
  logic                    ov_n;
  logic [KEYWORD_COUNT-1:0] ka_n;
  token_t     tk [4];
  logic [2:0] cnt;

  logic [7:0] c;
  logic       is_dig, is_st, is_pt, is_ws;
  logic [34:0] mul;

  // accumulator times ten plus the digit value, used only for the digit step
  assign mul = {4'd0, number_accumulator} * 35'd10 + 35'(q_byte - 8'h30);

  assign c = q_byte;
  assign is_dig = q_cls.digit;
  assign is_st = q_cls.start;
  assign is_pt = q_cls.part;
  assign is_ws = q_cls.ws;

  function automatic token_t mk(input logic [5:0] k, input logic [1:0] e,
      input logic [OFFSET_WIDTH-1:0] o, input logic [7:0] l,
      input logic [LINE_WIDTH-1:0] ln, input logic [LINE_WIDTH-1:0] col,
      input logic [30:0] v, input logic f, input logic ov);
    token_t t;
    t.kind = k; t.err = e; t.offset = o; t.length = l; t.line = ln;
    t.column = col; t.value = v; t.frac = f; t.ovf = ov; t.last = 1'b0;
    return t;
  endfunction

  function automatic logic [7:0] gr(input logic [7:0] l);
    return (l == 8'hFF) ? l : l + 8'd1;
  endfunction

  function automatic logic [5:0] op_single(input logic [2:0] p);
    case (p)
      3'd1: return K_ASSIGN;
      3'd2: return K_NOT;
      3'd3: return K_LT;
      3'd4: return K_GT;
      3'd7: return K_DIV;
      default: return K_ERROR;
    endcase
  endfunction

  function automatic logic [5:0] op_double(input logic [2:0] p);
    case (p)
      3'd1: return K_EQ;
      3'd2: return K_NE;
      3'd3: return K_LE;
      3'd4: return K_GE;
      3'd5: return K_AND;
      default: return K_OR;
    endcase
  endfunction

  function automatic logic [7:0] op_second(input logic [2:0] p);
    case (p)
      3'd5: return 8'h26;
      3'd6: return 8'h7C;
      3'd7: return 8'h2F;
      default: return 8'h3D;
    endcase
  endfunction

  // scanner step for one byte: one rescan at most, then the close
  always_comb begin
    logic rescan, consumed, dot_err;
    logic [5:0] kd;
    logic [4:0] ntl;
    logic [KEYWORD_COUNT-1:0] kstep;
    m_n = scan_mode; p_n = pending_operator; bo_n = byte_offset;
    so_n = start_offset; lc_n = length_count; ln_n = line_count;
    cn_n = column_count; sl_n = start_line; sc_n = start_column;
    acc_n = number_accumulator; ov_n = overflow_seen; ka_n = keyword_alive;
    cnt = 3'd0; rescan = 1'b0; consumed = 1'b0; dot_err = 1'b0; kd = K_IDENT;
    ntl = '0;
    for (int i = 0; i < 4; i++) tk[i] = '0;
    // keyword compare at the current length, against every rom row
    for (int k = 0; k < KEYWORD_COUNT; k++)
      kstep[k] = (length_count < 8'(KEYWORD_MAX_BYTES)) && (length_count < kw_len(4'(k)))
               && (kw_byte(4'(k), length_count) == c);
    // word kind from the alive bits
    for (int k = KEYWORD_COUNT - 1; k >= 0; k--)
      if (keyword_alive[k] && kw_len(4'(k)) == length_count) kd = 6'(k + 1);

    if (c != 8'd0) begin
      // first pass over the current mode
      unique case (scan_mode)
        M_IDENT: if (is_pt) begin
          ka_n = keyword_alive & kstep; lc_n = gr(length_count); consumed = 1'b1;
        end else begin
          tk[cnt[1:0]] = mk(kd, E_NONE, start_offset, length_count, start_line,
                            start_column, '0, 1'b0, 1'b0);
          cnt = cnt + 3'd1; rescan = 1'b1;
        end
        M_NUMBER: if (is_dig) begin
          if (mul > 35'(VALUE_MAX)) begin acc_n = VALUE_MAX; ov_n = 1'b1; end
          else acc_n = mul[30:0];
          lc_n = gr(length_count); consumed = 1'b1;
        end else if (c == 8'h2E) begin
          m_n = M_NUM_DOT; consumed = 1'b1;
        end else begin
          tk[cnt[1:0]] = mk(K_NUMBER, E_NONE, start_offset, length_count, start_line,
                            start_column, number_accumulator, 1'b0, overflow_seen);
          cnt = cnt + 3'd1; rescan = 1'b1;
        end
        M_NUM_DOT: if (is_dig) begin
          lc_n = gr(gr(length_count)); m_n = M_FRACTION; consumed = 1'b1;
        end else begin
          tk[cnt[1:0]] = mk(K_NUMBER, E_NONE, start_offset, length_count, start_line,
                            start_column, number_accumulator, 1'b0, overflow_seen);
          tk[cnt[1:0] + 2'd1] = mk(K_ERROR, E_UNEXPECTED,
                         (byte_offset != '0) ? byte_offset - 1'b1 : '0, 8'd1, line_count,
                         (column_count > 1) ? column_count - 1'b1 : LINE_WIDTH'(1),
                         '0, 1'b0, 1'b0);
          cnt = cnt + 3'd2; rescan = 1'b1;
        end
        M_FRACTION: if (is_dig) begin
          lc_n = gr(length_count); consumed = 1'b1;
        end else begin
          tk[cnt[1:0]] = mk(K_NUMBER, E_NONE, start_offset, length_count, start_line,
                            start_column, number_accumulator, 1'b1, overflow_seen);
          cnt = cnt + 3'd1; rescan = 1'b1;
        end
        M_STRING: begin
          lc_n = gr(length_count); consumed = 1'b1;
          if (c == 8'h22) begin
            tk[cnt[1:0]] = mk(K_STRING, E_NONE, start_offset, lc_n, start_line,
                              start_column, '0, 1'b0, 1'b0);
            cnt = cnt + 3'd1; m_n = M_IDLE;
          end
        end
        M_COMMENT: begin
          if (c == 8'h0A) begin m_n = M_IDLE; rescan = 1'b1; end
          else consumed = 1'b1;
        end
        M_OP: begin
          if (c != op_second(pending_operator)) begin
            kd = op_single(pending_operator);
            tk[cnt[1:0]] = mk(kd, (kd == K_ERROR) ? E_UNEXPECTED : E_NONE, start_offset,
                              length_count, start_line, start_column, '0, 1'b0, 1'b0);
            cnt = cnt + 3'd1; rescan = 1'b1;
          end else begin
            consumed = 1'b1;
            if (pending_operator == 3'd7) m_n = M_COMMENT;
            else begin
              lc_n = gr(length_count);
              tk[cnt[1:0]] = mk(op_double(pending_operator), E_NONE, start_offset, lc_n,
                                start_line, start_column, '0, 1'b0, 1'b0);
              cnt = cnt + 3'd1; m_n = M_IDLE;
            end
          end
          p_n = 3'd0;
        end
        default: rescan = 1'b1;
      endcase
      // idle pass: whitespace or a new token
      if (rescan) begin
        m_n = M_IDLE; consumed = 1'b1;
        if (!is_ws) begin
          so_n = byte_offset; sl_n = line_count; sc_n = column_count;
          lc_n = 8'd1;
          if (is_st) begin
            for (int k = 0; k < KEYWORD_COUNT; k++)
              ka_n[k] = (kw_len(4'(k)) != 8'd0) && (kw_byte(4'(k), 8'd0) == c);
            m_n = M_IDENT;
          end else if (is_dig) begin
            acc_n = 31'(c - 8'h30); ov_n = 1'b0; m_n = M_NUMBER;
          end else begin
            kd = K_ERROR;
            case (c)
              8'h22: m_n = M_STRING;
              8'h28: kd = K_LPAREN;
              8'h29: kd = K_RPAREN;
              8'h7B: kd = K_LBRACE;
              8'h7D: kd = K_RBRACE;
              8'h3B: kd = K_SEMI;
              8'h2C: kd = K_COMMA;
              8'h2B: kd = K_PLUS;
              8'h2D: kd = K_MINUS;
              8'h2A: kd = K_STAR;
              8'h25: kd = K_MOD;
              8'h3D: begin p_n = 3'd1; m_n = M_OP; end
              8'h21: begin p_n = 3'd2; m_n = M_OP; end
              8'h3C: begin p_n = 3'd3; m_n = M_OP; end
              8'h3E: begin p_n = 3'd4; m_n = M_OP; end
              8'h26: begin p_n = 3'd5; m_n = M_OP; end
              8'h7C: begin p_n = 3'd6; m_n = M_OP; end
              8'h2F: begin p_n = 3'd7; m_n = M_OP; end
              default: ;
            endcase
            if (m_n == M_IDLE) begin
              tk[cnt[1:0]] = mk(kd, (kd == K_ERROR) ? E_UNEXPECTED : E_NONE, byte_offset,
                                8'd1, line_count, column_count, '0, 1'b0, 1'b0);
              cnt = cnt + 3'd1;
            end
          end
        end
      end
      // position counters
      if (consumed) begin
        bo_n = (byte_offset == OFF_MAX) ? byte_offset : byte_offset + 1'b1;
        if (c == 8'h0A) begin
          ln_n = (line_count == LINE_MAX) ? line_count : line_count + 1'b1;
          cn_n = LINE_WIDTH'(1);
        end else cn_n = (column_count == LINE_MAX) ? column_count : column_count + 1'b1;
      end
    end
    // close of source: pending token, a dot error if any, then eof
    if (c == 8'd0 || q_end) begin
      kd = K_IDENT;
      for (int k = KEYWORD_COUNT - 1; k >= 0; k--)
        if (ka_n[k] && kw_len(4'(k)) == lc_n) kd = 6'(k + 1);
      dot_err = 1'b0;
      unique case (m_n)
        M_IDENT: begin
          tk[cnt[1:0]] = mk(kd, E_NONE, so_n, lc_n, sl_n, sc_n, '0, 1'b0, 1'b0);
          cnt = cnt + 3'd1;
        end
        M_NUMBER, M_NUM_DOT, M_FRACTION: begin
          tk[cnt[1:0]] = mk(K_NUMBER, E_NONE, so_n, lc_n, sl_n, sc_n, acc_n,
                            m_n == M_FRACTION, ov_n);
          cnt = cnt + 3'd1; dot_err = (m_n == M_NUM_DOT);
        end
        M_STRING: begin
          tk[cnt[1:0]] = mk(K_ERROR, E_UNTERMINATED, so_n, lc_n, sl_n, sc_n, '0, 1'b0,
                            1'b0);
          cnt = cnt + 3'd1;
        end
        M_OP: begin
          kd = op_single(p_n);
          tk[cnt[1:0]] = mk(kd, (kd == K_ERROR) ? E_UNEXPECTED : E_NONE, so_n, lc_n, sl_n,
                            sc_n, '0, 1'b0, 1'b0);
          cnt = cnt + 3'd1;
        end
        default: ;
      endcase
      if (dot_err) begin
        tk[cnt[1:0]] = mk(K_ERROR, E_UNEXPECTED, (bo_n != '0) ? bo_n - 1'b1 : '0, 8'd1,
                          ln_n, (cn_n > 1) ? cn_n - 1'b1 : LINE_WIDTH'(1), '0, 1'b0, 1'b0);
        cnt = cnt + 3'd1;
      end
      tk[cnt[1:0]] = mk(K_EOF, E_NONE, bo_n, 8'd0, ln_n, cn_n, '0, 1'b0, 1'b0);
      cnt = cnt + 3'd1;
      m_n = M_IDLE; p_n = 3'd0; bo_n = '0; so_n = '0; lc_n = 8'd0;
      ln_n = LINE_WIDTH'(1); cn_n = LINE_WIDTH'(1); sl_n = LINE_WIDTH'(1);
      sc_n = LINE_WIDTH'(1); acc_n = '0; ov_n = 1'b0; ka_n = '1;
    end
    ntl = 5'(cnt);
    if (ntl != 5'd0) tk[ntl[1:0] - 2'd1].last = 1'b1;
  end

  // a byte is taken once the previous byte's tokens are all loaded into the output register
  logic emit_free;
  logic out_take;
  assign out_take = out_valid && !out_stall;
  assign emit_free = !out_valid || out_take;
  assign q_pop = q_valid && !busy;

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= M_IDLE; pending_operator <= 3'd0; byte_offset <= '0;
      start_offset <= '0; length_count <= 8'd0; line_count <= LINE_WIDTH'(1);
      column_count <= LINE_WIDTH'(1); start_line <= LINE_WIDTH'(1);
      start_column <= LINE_WIDTH'(1); number_accumulator <= '0;
      overflow_seen <= 1'b0; keyword_alive <= '1;
      busy <= 1'b0; tl_count <= 3'd0; tl_idx <= 3'd0; out_valid <= 1'b0;
    end else begin
      if (out_take && !(busy && emit_free)) out_valid <= 1'b0;
      if (q_pop) begin
        scan_mode <= m_n; pending_operator <= p_n; byte_offset <= bo_n;
        start_offset <= so_n; length_count <= lc_n; line_count <= ln_n;
        column_count <= cn_n; start_line <= sl_n; start_column <= sc_n;
        number_accumulator <= acc_n; overflow_seen <= ov_n; keyword_alive <= ka_n;
        for (int i = 0; i < 4; i++) tl[i] <= tk[i];
        tl_count <= cnt; tl_idx <= 3'd0;
        busy <= (cnt != 3'd0);
      end else if (busy && emit_free) begin
        out_tok <= tl[tl_idx[1:0]];
        out_valid <= 1'b1;
        tl_idx <= tl_idx + 3'd1;
        if (tl_idx + 3'd1 == tl_count) busy <= 1'b0;
      end
    end
  end

  `SBT_ASSERT_IMP(a_no_pop_busy, q_pop, !busy, "byte taken while tokens pending")
  `SBT_ASSERT_IMP(a_idx_range, busy, tl_idx < tl_count, "token index past list")
  `SBT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_tok),
                   "stalled token changed")
endmodule
`default_nettype wire

FILE: rtl/source_byte_tokenizer.sv
// Source byte tokenizer top level: byte queue front end and scanner back end.
// A byte passes from the byte queue into the scanner's token list, and its tokens
// go on from there into the output register one at a time.
// The scanner takes no new byte until every token the last one yields (0 to 4)
// has been loaded into the single token output register.
// Reset: synchronous rst clears the queue, the scanner to idle at offset 0, line 1, col 1.
`timescale 1ns / 1ps
`default_nettype none
module source_byte_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  source_byte,
  input  wire logic        end_of_source,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       token_kind,
  output logic [1:0]       error_code,
  output logic [23:0]      token_offset,
  output logic [7:0]       token_length,
  output logic [15:0]      token_line,
  output logic [15:0]      token_column,
  output logic [30:0]      number_value,
  output logic             has_fraction,
  output logic             value_overflow,
  output logic             last_of_run
);
  import sbt_pkg::*;

  logic        q_valid, q_pop, q_end;
  logic [7:0]  q_byte;
  byte_class_t q_cls;
  token_t      tok;

  // byte queue
  sbt_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_byte(source_byte), .in_end(end_of_source),
    .q_valid, .q_pop, .q_byte, .q_cls, .q_end
  );

  // scanner
  sbt_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_byte, .q_cls, .q_end, .out_valid, .out_stall,
    .out_tok(tok)
  );

  // result beat fields
  assign token_kind = tok.kind;
  assign error_code = tok.err;
  assign token_offset = tok.offset;
  assign token_length = tok.length;
  assign token_line = tok.line;
  assign token_column = tok.column;
  assign number_value = tok.value;
  assign has_fraction = tok.frac;
  assign value_overflow = tok.ovf;
  assign last_of_run = tok.last;
endmodule
`default_nettype wire
